// ===== rtl/ftws_pkg.sv =====
// Shared types and constants for the frame time window statistics block.
// Depends on nothing; every file but ftws_ram and ftws_div imports it.
package ftws_pkg;

  // Fixed field widths.
  localparam int unsigned TIME_W  = 20;
  localparam int unsigned FPS_W   = 24;
  localparam int unsigned VAR_W   = 38;
  localparam int unsigned TOTAL_W = 32;
  localparam int unsigned RUN_W   = 16;
  localparam int unsigned CIDX_W  = 3;

  // Arithmetic constants.
  localparam logic [27:0]        FPS_Q8_NUM    = 28'd256000000;
  localparam logic [FPS_W-1:0]   FPS_MAX       = 24'hFFFFFF;
  localparam logic [VAR_W-1:0]   VAR_MAX       = 38'h3FFFFFFFFF;
  localparam logic [VAR_W-1:0]   VAR_STABLE    = 38'd1000000000;
  localparam logic [FPS_W:0]     SPREAD_STABLE = 25'd1280;
  localparam logic [TIME_W-1:0]  SMOOTH_RESET  = 20'd16667;
  localparam logic [31:0]        RECIP10       = 32'hCCCCCCCD;

  // Register reset values.
  localparam logic [TIME_W-1:0]  TARGET_RESET  = 20'd16667;
  localparam logic [TIME_W-1:0]  MARGIN_RESET  = 20'd20000;

  // Configuration register indexes.
  typedef enum logic [CIDX_W-1:0] {
    CFG_TARGET = 3'd0,
    CFG_MARGIN = 3'd1,
    CFG_VSYNC  = 3'd2,
    CFG_SKIP   = 3'd3,
    CFG_SMOOTH = 3'd4
  } cfg_index_t;

  // One classified frame handed from the front part to the back part.
  typedef struct packed {
    logic [TIME_W-1:0]  frame_time_us;
    logic [TOTAL_W-1:0] hitch_total;
    logic [RUN_W-1:0]   hitch_run;
    logic               hitch_warning;
    logic [TIME_W-1:0]  smoothed_time_us;
    logic               skip_next;
  } front_entry_t;

endpackage

// ===== rtl/ftws_cfg_if.sv =====
// Configuration write channel: register index and write data.
// Depends on ftws_pkg.
interface ftws_cfg_if import ftws_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CIDX_W-1:0]   index;
  logic [TIME_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/ftws_in_if.sv =====
// Input channel carrying one measured frame time per transaction.
// Depends on ftws_pkg.
interface ftws_in_if import ftws_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [TIME_W-1:0]   frame_time_us;

  modport source (output valid, frame_time_us, input ready);
  modport sink   (input valid, frame_time_us, output ready);
endinterface

// ===== rtl/ftws_out_if.sv =====
// Result channel carrying the statistics of one frame per transaction.
// Depends on ftws_pkg.
interface ftws_out_if import ftws_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [FPS_W-1:0]    average_fps_q8;
  logic [FPS_W-1:0]    min_fps_q8;
  logic [FPS_W-1:0]    max_fps_q8;
  logic [VAR_W-1:0]    variance_us2;
  logic                stable;
  logic [TOTAL_W-1:0]  hitch_total;
  logic [RUN_W-1:0]    hitch_run;
  logic                hitch_warning;
  logic [TIME_W-1:0]   smoothed_time_us;
  logic                skip_next;

  modport source (output valid, average_fps_q8, min_fps_q8, max_fps_q8, variance_us2,
                  stable, hitch_total, hitch_run, hitch_warning, smoothed_time_us,
                  skip_next, input ready);
  modport sink   (input valid, average_fps_q8, min_fps_q8, max_fps_q8, variance_us2,
                  stable, hitch_total, hitch_run, hitch_warning, smoothed_time_us,
                  skip_next, output ready);
endinterface

// ===== rtl/ftws_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// Depends on nothing.
module ftws_ram #(
  parameter int unsigned WIDTH = 20,
  parameter int unsigned DEPTH = 64
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(DEPTH)-1:0]   waddr,
  input  logic [WIDTH-1:0]           wdata,
  input  logic                       re,
  input  logic [$clog2(DEPTH)-1:0]   raddr,
  output logic [WIDTH-1:0]           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/ftws_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on nothing. A zero divisor gives an all ones quotient.
module ftws_div #(
  parameter int unsigned NW = 54,
  parameter int unsigned DW = 27
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [NW-1:0]  num,
  input  logic [DW-1:0]  den,
  output logic           done,
  output logic [NW-1:0]  quot
);

  localparam int unsigned CNT_W = $clog2(NW + 1);

  logic [DW-1:0]    rem;
  logic [DW-1:0]    den_r;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DW:0]      rem_sh;
  logic             fits;

  // Shift in the next dividend bit and try the subtraction.
  assign rem_sh = {rem, quot[NW-1]};
  assign fits   = rem_sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= CNT_W'(NW);
        rem   <= '0;
        den_r <= den;
        quot  <= num;
      end else if (busy) begin
        rem  <= fits ? DW'(rem_sh - {1'b0, den_r}) : rem_sh[DW-1:0];
        quot <= {quot[NW-2:0], fits};
        cnt  <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/ftws_queue.sv =====
// Two entry queue of classified frames between the front and back parts.
// Depends on ftws_pkg.
module ftws_queue import ftws_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  front_entry_t  push_data,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output front_entry_t  head
);

  front_entry_t slots [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;

  assign full  = count == 2'd2;
  assign empty = count == 2'd0;
  assign head  = slots[rd_ptr];

  // Pointer and count update.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== rtl/ftws_front.sv =====
// Front part: configuration registers, hitch counting, smoothing and skip test.
// Depends on ftws_pkg and the channel interfaces; feeds ftws_queue.
module ftws_front import ftws_pkg::*; #(
  parameter int unsigned HITCH_LIMIT = 3
) (
  input  logic          clk,
  input  logic          rst,
  ftws_cfg_if.sink      cfg,
  ftws_in_if.sink       frame_in,
  input  logic          q_full,
  output logic          q_push,
  output front_entry_t  q_data
);

  logic [TIME_W-1:0]  target_time;
  logic [TIME_W-1:0]  hitch_margin;
  logic               vsync_on;
  logic               skip_on;
  logic               smooth_on;
  logic [TIME_W-1:0]  smoothed;
  logic [RUN_W-1:0]   hitch_run;
  logic [TOTAL_W-1:0] hitch_total;

  logic [TIME_W-1:0]  x;
  logic               hitch;
  logic [RUN_W-1:0]   hitch_run_next;
  logic [TOTAL_W-1:0] hitch_total_next;
  logic               warn;
  logic [23:0]        smooth_sum;
  logic [55:0]        smooth_prod;
  logic [TIME_W-1:0]  smoothed_next;
  logic               skip;

  assign cfg.ready      = 1'b1;
  assign frame_in.ready = !q_full;
  assign q_push         = frame_in.valid && !q_full;
  assign x              = frame_in.frame_time_us;

  // Hitch classification with saturating counters.
  always_comb begin
    hitch            = {1'b0, x} > ({1'b0, target_time} + {1'b0, hitch_margin});
    hitch_run_next   = hitch_run;
    hitch_total_next = hitch_total;
    warn             = 1'b0;
    if (vsync_on) begin
      if (hitch) begin
        if (hitch_run != '1) begin
          hitch_run_next = hitch_run + 1'b1;
        end
        if (hitch_total != '1) begin
          hitch_total_next = hitch_total + 1'b1;
        end
        warn = {1'b0, hitch_run_next} >= 17'(HITCH_LIMIT);
      end else begin
        hitch_run_next = '0;
      end
    end
  end

  // Smoothing: (x + 9 * s + 5) / 10 by reciprocal multiplication.
  assign smooth_sum    = {4'b0, x} + {1'b0, smoothed, 3'b0} + {4'b0, smoothed} + 24'd5;
  assign smooth_prod   = 56'(smooth_sum) * 56'(RECIP10);
  assign smoothed_next = smooth_on ? smooth_prod[54:35] : x;

  // Skip when twice the frame exceeds three times the target.
  assign skip = skip_on && ({1'b0, x, 1'b0} > ({2'b0, target_time} + {1'b0, target_time, 1'b0}));

  always_comb begin
    q_data.frame_time_us    = x;
    q_data.hitch_total      = hitch_total_next;
    q_data.hitch_run        = hitch_run_next;
    q_data.hitch_warning    = warn;
    q_data.smoothed_time_us = smoothed_next;
    q_data.skip_next        = skip;
  end

  // Configuration writes and per frame state.
  always_ff @(posedge clk) begin
    if (rst) begin
      target_time  <= TARGET_RESET;
      hitch_margin <= MARGIN_RESET;
      vsync_on     <= 1'b0;
      skip_on      <= 1'b0;
      smooth_on    <= 1'b1;
      smoothed     <= SMOOTH_RESET;
      hitch_run    <= '0;
      hitch_total  <= '0;
    end else begin
      if (cfg.valid) begin
        unique case (cfg_index_t'(cfg.index))
          CFG_TARGET: target_time  <= cfg.data;
          CFG_MARGIN: hitch_margin <= cfg.data;
          CFG_VSYNC:  vsync_on     <= cfg.data[0];
          CFG_SKIP:   skip_on      <= cfg.data[0];
          CFG_SMOOTH: smooth_on    <= cfg.data[0];
          default: ;
        endcase
      end
      if (q_push) begin
        smoothed    <= smoothed_next;
        hitch_run   <= hitch_run_next;
        hitch_total <= hitch_total_next;
      end
    end
  end

endmodule

// ===== rtl/ftws_back.sv =====
// Back part: window storage, window walk, products, shared divider, result register.
// Depends on ftws_pkg, ftws_ram, ftws_div and the result interface.
module ftws_back import ftws_pkg::*; #(
  parameter int unsigned WINDOW = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_empty,
  input  front_entry_t  q_head,
  output logic          q_pop,
  ftws_out_if.source    stats_out
);

  localparam int unsigned AW   = $clog2(WINDOW);
  localparam int unsigned CW   = $clog2(WINDOW + 1);
  localparam int unsigned SW   = TIME_W + CW;
  localparam int unsigned QW   = 2 * TIME_W + CW;
  localparam int unsigned NUMW = 2 * SW;
  localparam int unsigned PBW  = QW - 32 + CW;

  typedef enum logic [3:0] {
    S_IDLE, S_WRITE, S_WALK, S_MUL1, S_MUL2, S_MUL3, S_DSTART, S_DWAIT, S_FINAL
  } state_t;

  typedef enum logic [1:0] {DSEL_AVG, DSEL_MIN, DSEL_MAX, DSEL_VAR} div_sel_t;

  state_t        state;
  div_sel_t      div_sel;
  front_entry_t  cur;
  logic [AW-1:0] head;
  logic [CW-1:0] fill;
  logic [CW-1:0] rd_idx;
  logic          v1;
  logic          v2;
  logic [TIME_W-1:0]   rdata;
  logic [TIME_W-1:0]   s2;
  logic [2*TIME_W-1:0] sq;
  logic [SW-1:0]       sum;
  logic [QW-1:0]       sumsq;
  logic [TIME_W-1:0]   lo;
  logic [TIME_W-1:0]   hi;
  logic [31+CW:0]      prod_a;
  logic [PBW-1:0]      prod_b;
  logic [NUMW-1:0]     prod_c;
  logic [2*CW-1:0]     den_sq;
  logic [27+CW:0]      avg_num;
  logic [NUMW-1:0]     var_num;
  logic [FPS_W-1:0]    avg_fps;
  logic [FPS_W-1:0]    min_fps;
  logic [FPS_W-1:0]    max_fps;
  logic [VAR_W-1:0]    var_val;
  logic                rd_en;
  logic                div_start;
  logic                div_done;
  logic [NUMW-1:0]     div_num;
  logic [SW-1:0]       div_den;
  logic [NUMW-1:0]     div_quot;
  logic [FPS_W-1:0]    fps_q;
  logic [VAR_W-1:0]    var_q;
  logic                stable_now;

  logic                out_valid;
  logic [FPS_W-1:0]    o_avg;
  logic [FPS_W-1:0]    o_min;
  logic [FPS_W-1:0]    o_max;
  logic [VAR_W-1:0]    o_var;
  logic                o_stable;
  front_entry_t        o_ent;

  assign q_pop     = (state == S_IDLE) && !q_empty;
  assign rd_en     = (state == S_WALK) && (rd_idx < fill);
  assign div_start = state == S_DSTART;

  ftws_ram #(.WIDTH(TIME_W), .DEPTH(WINDOW)) u_window (
    .clk   (clk),
    .we    (state == S_WRITE),
    .waddr (head),
    .wdata (cur.frame_time_us),
    .re    (rd_en),
    .raddr (rd_idx[AW-1:0]),
    .rdata (rdata)
  );

  // Operand selection for the shared divider.
  always_comb begin
    div_num = NUMW'(FPS_Q8_NUM);
    div_den = SW'(hi);
    case (div_sel)
      DSEL_AVG: begin
        div_num = NUMW'(avg_num);
        div_den = sum;
      end
      DSEL_MIN: div_den = SW'(hi);
      DSEL_MAX: div_den = SW'(lo);
      DSEL_VAR: begin
        div_num = var_num;
        div_den = SW'(den_sq);
      end
      default: ;
    endcase
  end

  ftws_div #(.NW(NUMW), .DW(SW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Saturated quotients and the stability test.
  assign fps_q      = (div_quot > NUMW'(FPS_MAX)) ? FPS_MAX : div_quot[FPS_W-1:0];
  assign var_q      = (div_quot > NUMW'(VAR_MAX)) ? VAR_MAX : div_quot[VAR_W-1:0];
  assign stable_now = (({1'b0, max_fps} - {1'b0, min_fps}) < SPREAD_STABLE)
                      && (var_val < VAR_STABLE);

  // Sequencer, window walk and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      div_sel   <= DSEL_AVG;
      head      <= '0;
      fill      <= '0;
      rd_idx    <= '0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // The final state reloads the result register itself.
      if (stats_out.ready && (state != S_FINAL)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (!q_empty) begin
            cur   <= q_head;
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          head   <= (head == AW'(WINDOW - 1)) ? '0 : head + 1'b1;
          if (fill != CW'(WINDOW)) begin
            fill <= fill + 1'b1;
          end
          rd_idx <= '0;
          v1     <= 1'b0;
          v2     <= 1'b0;
          sum    <= '0;
          sumsq  <= '0;
          lo     <= '1;
          hi     <= '0;
          state  <= S_WALK;
        end
        S_WALK: begin
          if (rd_en) begin
            rd_idx <= rd_idx + 1'b1;
          end
          v1 <= rd_en;
          v2 <= v1;
          if (v1) begin
            sq <= rdata * rdata;
            s2 <= rdata;
          end
          if (v2) begin
            sum   <= sum + SW'(s2);
            sumsq <= sumsq + QW'(sq);
            if (s2 < lo) begin
              lo <= s2;
            end
            if (s2 > hi) begin
              hi <= s2;
            end
          end
          if ((rd_idx == fill) && !v1 && !v2) begin
            state <= S_MUL1;
          end
        end
        S_MUL1: begin
          prod_a  <= sumsq[31:0] * fill;
          avg_num <= FPS_Q8_NUM * fill;
          state   <= S_MUL2;
        end
        S_MUL2: begin
          prod_b <= sumsq[QW-1:32] * fill;
          prod_c <= sum * sum;
          den_sq <= fill * fill;
          state  <= S_MUL3;
        end
        S_MUL3: begin
          var_num <= (NUMW'(prod_b) << 32) + NUMW'(prod_a) - prod_c;
          div_sel <= DSEL_AVG;
          state   <= S_DSTART;
        end
        S_DSTART: begin
          state <= S_DWAIT;
        end
        S_DWAIT: begin
          if (div_done) begin
            case (div_sel)
              DSEL_AVG: avg_fps <= fps_q;
              DSEL_MIN: min_fps <= fps_q;
              DSEL_MAX: max_fps <= fps_q;
              DSEL_VAR: var_val <= var_q;
              default: ;
            endcase
            if (div_sel == DSEL_VAR) begin
              state <= S_FINAL;
            end else begin
              div_sel <= div_sel_t'(div_sel + 2'd1);
              state   <= S_DSTART;
            end
          end
        end
        S_FINAL: begin
          if (!out_valid || stats_out.ready) begin
            out_valid <= 1'b1;
            o_avg     <= avg_fps;
            o_min     <= min_fps;
            o_max     <= max_fps;
            o_var     <= var_val;
            o_stable  <= stable_now;
            o_ent     <= cur;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign stats_out.valid            = out_valid;
  assign stats_out.average_fps_q8   = o_avg;
  assign stats_out.min_fps_q8       = o_min;
  assign stats_out.max_fps_q8       = o_max;
  assign stats_out.variance_us2     = o_var;
  assign stats_out.stable           = o_stable;
  assign stats_out.hitch_total      = o_ent.hitch_total;
  assign stats_out.hitch_run        = o_ent.hitch_run;
  assign stats_out.hitch_warning    = o_ent.hitch_warning;
  assign stats_out.smoothed_time_us = o_ent.smoothed_time_us;
  assign stats_out.skip_next        = o_ent.skip_next;

  // The fill count never passes the window depth.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CW'(WINDOW)) else $error("window fill beyond depth");

  // After a walk the window is non-empty, so the shortest sample is no longer than the longest.
  a_lo_hi: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL1) |-> (lo <= hi)) else $error("window minimum above maximum");

  // The window sum covers at least its largest sample.
  a_sum_hi: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL1) |-> (sum >= SW'(hi))) else $error("window sum below maximum");

  // A pop, made only when the back part is idle and a frame waits, starts that frame in the write state.
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> (state == S_WRITE)) else $error("pop without starting a frame");

endmodule

// ===== rtl/frame_time_window_statistics.sv =====
// Top level of the frame time window statistics block.
// Depends on ftws_pkg, the channel interfaces, ftws_front, ftws_queue and ftws_back.
//
//  Channel    Direction  Carries
//  cfg        in         register index and write data, always ready
//  frame_in   in         one frame time in microseconds per transaction
//  stats_out  out        window statistics, hitch counters, smoothing, skip flag
//
// In the back part the walk reads the n entries of the current window fill, one per cycle
// through the single RAM read port, and one bit-serial divider forms four quotients.
// The front part classifies a frame in the cycle it is accepted; a two entry queue
// accepts frames until it is full while the back part works or a result waits.
// Reset is synchronous; the window memory is not cleared, only its fill count is.
module frame_time_window_statistics import ftws_pkg::*; #(
  parameter int unsigned WINDOW      = 64,
  parameter int unsigned HITCH_LIMIT = 3
) (
  input  logic        clk,
  input  logic        rst,
  ftws_cfg_if.sink    cfg,
  ftws_in_if.sink     frame_in,
  ftws_out_if.source  stats_out
);

  logic         q_push;
  logic         q_full;
  logic         q_pop;
  logic         q_empty;
  front_entry_t q_data;
  front_entry_t q_head;

  ftws_front #(.HITCH_LIMIT(HITCH_LIMIT)) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .frame_in (frame_in),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_data)
  );

  ftws_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  ftws_back #(.WINDOW(WINDOW)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .stats_out (stats_out)
  );

endmodule
